// ----- sv/bilinear_bayer_demosaic_core_defines.svh -----
// Assertion helpers for the demosaic core.
`ifndef BILINEAR_BAYER_DEMOSAIC_CORE_DEFINES_SVH
`define BILINEAR_BAYER_DEMOSAIC_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BBD_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define BBD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`define BBD_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);
`else
`define BBD_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define BBD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`define BBD_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`endif
`endif

// ----- sv/bbd_pkg.sv -----
`timescale 1ns / 1ps
package bbd_pkg;
   localparam int PIX_W          = 8;
   localparam int FRAME_WIDTH_W  = 11;
   localparam int FRAME_HEIGHT_W = 13;
   localparam int CSR_DATA_W     = 13;
   localparam int IN_ROW_W       = 13;
   localparam int OUT_ROW_W      = 12;
   localparam int WIDTH_MIN      = 2;
   localparam int HEIGHT_MIN     = 2;
   localparam int HEIGHT_MAX     = 4096;
   localparam int WIDTH_RESET    = 1024;
   localparam int HEIGHT_RESET   = 1024;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   typedef enum logic {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // one column of the 3x3 window: rows above, at and below the centre
   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bot;
   } col_type;

   typedef struct packed {
      logic emit;
      logic frame_end;
      logic top_zero;
      logic bot_zero;
      logic left_zero;
      logic right_zero;
      logic odd_row;
      logic odd_col;
   } pix_ctl_type;

   typedef struct packed {
      pix_ctl_type ctl;
      col_type     col;
   } entry_type;

   typedef struct packed {
      logic [QUEUE_CNT_W-1:0] count;
   } q_status_type;
endpackage

// ----- sv/bbd_if.sv -----
`timescale 1ns / 1ps
interface bbd_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] raw_pixel;
   modport source (output valid, output operation, output raw_pixel, input ready);
   modport sink (input valid, input operation, input raw_pixel, output ready);
endinterface

interface bbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       frame_end;
   modport source (output valid, output red, output green, output blue, output frame_end,
                   input ready);
   modport sink (input valid, input red, input green, input blue, input frame_end,
                 output ready);
endinterface

// ----- sv/bbd_ram.sv -----
`timescale 1ns / 1ps
module bbd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- sv/bbd_front.sv -----
`timescale 1ns / 1ps
`include "bilinear_bayer_demosaic_core_defines.svh"
module bbd_front import bbd_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   bbd_req_if.sink               req_if,
   input  logic                  csr_we,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  q_status_type          q_status,
   output logic                  q_push,
   output entry_type             q_entry
);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int XW    = (WW > FRAME_WIDTH_W) ? WW : FRAME_WIDTH_W;
   localparam int LW    = 2 * PIX_W;
   localparam int OCC_W = QUEUE_CNT_W + 1;

   logic [FRAME_WIDTH_W-1:0]  frame_width_ff;
   logic [FRAME_HEIGHT_W-1:0] frame_height_ff;
   logic [CW-1:0]             in_col_ff, in_col_in;
   logic [IN_ROW_W-1:0]       in_row_ff, in_row_in;
   logic [CW-1:0]             out_col_ff, out_col_in;
   logic [OUT_ROW_W-1:0]      out_row_ff, out_row_in;
   logic                      b_valid_ff, b_valid_in;
   pix_ctl_type               b_ctl_ff;
   logic [PIX_W-1:0]          b_sample_ff;
   logic [CW-1:0]             b_addr_ff;

   logic [XW-1:0]             fw_ext;
   logic [WW-1:0]             eff_w;
   logic [CW-1:0]             w_last;
   logic [FRAME_HEIGHT_W-1:0] eff_h;
   logic [OUT_ROW_W-1:0]      h_last;
   logic [OCC_W-1:0]          occupancy;
   logic                      accept;
   logic                      is_flush;
   logic                      drop;
   logic                      emit;
   logic [PIX_W-1:0]          sample;
   pix_ctl_type               ctl;
   logic [LW-1:0]             line_rd;

   // clamp the size registers to the supported range
   always_comb begin
      fw_ext = XW'(frame_width_ff);
      if (fw_ext < XW'(WIDTH_MIN)) begin
         eff_w = WW'(WIDTH_MIN);
      end else if (fw_ext > XW'(MAX_WIDTH)) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(fw_ext);
      end
      w_last = CW'(eff_w - WW'(1));
      if (frame_height_ff < FRAME_HEIGHT_W'(HEIGHT_MIN)) begin
         eff_h = FRAME_HEIGHT_W'(HEIGHT_MIN);
      end else if (frame_height_ff > FRAME_HEIGHT_W'(HEIGHT_MAX)) begin
         eff_h = FRAME_HEIGHT_W'(HEIGHT_MAX);
      end else begin
         eff_h = frame_height_ff;
      end
      h_last = OUT_ROW_W'(eff_h - FRAME_HEIGHT_W'(1));
   end

   assign occupancy    = OCC_W'(q_status.count) + OCC_W'(b_valid_ff);
   assign req_if.ready = occupancy < OCC_W'(QUEUE_DEPTH);
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      is_flush = op_type'(req_if.operation) == OP_FLUSH;
      // a flush with no frame in progress is a no-op
      drop     = is_flush && (in_row_ff == '0) && (in_col_ff == '0);
      if ((in_row_ff >= eff_h) || is_flush) begin
         sample = '0;
      end else begin
         sample = req_if.raw_pixel;
      end
      emit = (in_row_ff >= IN_ROW_W'(2)) ||
             ((in_row_ff == IN_ROW_W'(1)) && (in_col_ff != '0));
      ctl.emit       = emit;
      ctl.frame_end  = emit && (out_row_ff == h_last) && (out_col_ff == w_last);
      ctl.top_zero   = out_row_ff == '0;
      ctl.bot_zero   = out_row_ff == h_last;
      ctl.left_zero  = out_col_ff == '0;
      ctl.right_zero = out_col_ff == w_last;
      ctl.odd_row    = out_row_ff[0];
      ctl.odd_col    = out_col_ff[0];
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      b_valid_in = accept && !drop;
      if (csr_we) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (accept && !drop) begin
         if (in_col_ff == w_last) begin
            in_col_in = '0;
            in_row_in = IN_ROW_W'(in_row_ff + 1'b1);
         end else begin
            in_col_in = CW'(in_col_ff + 1'b1);
         end
         if (emit) begin
            if (ctl.frame_end) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_col_ff == w_last) begin
               out_col_in = '0;
               out_row_in = OUT_ROW_W'(out_row_ff + 1'b1);
            end else begin
               out_col_in = CW'(out_col_ff + 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_W'(WIDTH_RESET);
         frame_height_ff <= FRAME_HEIGHT_W'(HEIGHT_RESET);
         in_col_ff       <= '0;
         in_row_ff       <= '0;
         out_col_ff      <= '0;
         out_row_ff      <= '0;
         b_valid_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[FRAME_WIDTH_W-1:0];
               CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[FRAME_HEIGHT_W-1:0];
            endcase
         end
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_ctl_ff    <= ctl;
         b_sample_ff <= sample;
         b_addr_ff   <= in_col_ff;
      end
   end

   // word = {two rows back, one row back}; read on transfer, rotated next cycle
   bbd_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_addr_ff),
      .wr_data ({line_rd[PIX_W-1:0], b_sample_ff}),
      .rd_addr (in_col_ff),
      .rd_data (line_rd)
   );

   always_comb begin
      q_push          = b_valid_ff;
      q_entry.ctl     = b_ctl_ff;
      q_entry.col.top = line_rd[LW-1:PIX_W];
      q_entry.col.mid = line_rd[PIX_W-1:0];
      q_entry.col.bot = b_sample_ff;
   end

   `BBD_ASSERT_NEXT(a_drop_no_stage, clock, reset, accept && drop, !b_valid_ff, "idle flush reached the line-store stage")
   `BBD_ASSERT_ALWAYS(a_credit, clock, reset, occupancy <= OCC_W'(QUEUE_DEPTH), "queue credit exceeded")
   `BBD_ASSERT_ALWAYS(a_col_bound, clock, reset, (in_col_ff <= w_last) && (out_col_ff <= w_last), "column counter past row end")
endmodule

// ----- sv/bbd_queue.sv -----
`timescale 1ns / 1ps
`include "bilinear_bayer_demosaic_core_defines.svh"
module bbd_queue import bbd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  entry_type    push_entry,
   input  logic         pop,
   output logic         head_valid,
   output entry_type    head_entry,
   output q_status_type status
);
   entry_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? QUEUE_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? QUEUE_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QUEUE_CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QUEUE_CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_valid   = count_ff != '0;
   assign head_entry   = slot_ff[rd_ptr_ff];
   assign status.count = count_ff;

   `BBD_ASSERT_IMPLY(a_no_overflow, clock, reset, push, (count_ff < QUEUE_CNT_W'(QUEUE_DEPTH)) || pop, "push into full queue")
   `BBD_ASSERT_IMPLY(a_no_underflow, clock, reset, pop, count_ff != '0, "pop from empty queue")
endmodule

// ----- sv/bbd_back.sv -----
`timescale 1ns / 1ps
`include "bilinear_bayer_demosaic_core_defines.svh"
module bbd_back import bbd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  entry_type head_entry,
   output logic      pop,
   bbd_rsp_if.source rsp_if
);
   localparam int SW = PIX_W + 2;
   localparam int HW = PIX_W + 1;

   // the two older window columns; the newest one is the queue head
   col_type          prev_ff;
   col_type          cur_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] red_ff, green_ff, blue_ff;
   logic             frame_end_ff;

   pix_ctl_type      c;
   col_type          nxt;
   logic             out_free;
   logic             load;
   logic [PIX_W-1:0] up, dn, lf, rt, ul, ur, dl, dr, cen;
   logic [SW-1:0]    cross_sum, diag_sum;
   logic [HW-1:0]    vert_sum, horz_sum;
   logic [PIX_W-1:0] cross_avg, diag, vert, horz;
   logic [PIX_W-1:0] red, green, blue;

   always_comb begin
      c        = head_entry.ctl;
      nxt      = head_entry.col;
      out_free = !rsp_valid_ff || rsp_if.ready;
      pop      = head_valid && (!c.emit || out_free);
      load     = pop && c.emit;

      // neighbors outside the frame read as zero
      cen = cur_ff.mid;
      up  = c.top_zero ? '0 : cur_ff.top;
      dn  = c.bot_zero ? '0 : cur_ff.bot;
      lf  = c.left_zero ? '0 : prev_ff.mid;
      rt  = c.right_zero ? '0 : nxt.mid;
      ul  = (c.top_zero || c.left_zero) ? '0 : prev_ff.top;
      ur  = (c.top_zero || c.right_zero) ? '0 : nxt.top;
      dl  = (c.bot_zero || c.left_zero) ? '0 : prev_ff.bot;
      dr  = (c.bot_zero || c.right_zero) ? '0 : nxt.bot;

      cross_sum = SW'(up) + SW'(dn) + SW'(lf) + SW'(rt);
      diag_sum  = SW'(ul) + SW'(ur) + SW'(dl) + SW'(dr);
      vert_sum  = HW'(up) + HW'(dn);
      horz_sum  = HW'(lf) + HW'(rt);
      cross_avg = cross_sum[SW-1:2];
      diag      = diag_sum[SW-1:2];
      vert      = vert_sum[HW-1:1];
      horz      = horz_sum[HW-1:1];

      // GBRG: even rows G B, odd rows R G
      unique if (c.odd_row && c.odd_col) begin
         red = horz;  green = cen;       blue = vert;
      end else if (c.odd_row && !c.odd_col) begin
         red = cen;   green = cross_avg; blue = diag;
      end else if (!c.odd_row && c.odd_col) begin
         red = diag;  green = cross_avg; blue = cen;
      end else begin
         red = vert;  green = cen;       blue = horz;
      end

      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         prev_ff <= cur_ff;
         cur_ff  <= nxt;
      end
      if (load) begin
         red_ff       <= red;
         green_ff     <= green;
         blue_ff      <= blue;
         frame_end_ff <= c.frame_end;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.red       = red_ff;
   assign rsp_if.green     = green_ff;
   assign rsp_if.blue      = blue_ff;
   assign rsp_if.frame_end = frame_end_ff;

   `BBD_ASSERT_NEXT(a_load_shows, clock, reset, load, rsp_valid_ff, "loaded pixel not presented")
endmodule

// ----- sv/bilinear_bayer_demosaic_core.sv -----
`timescale 1ns / 1ps
// Bilinear demosaic for a GBRG Bayer stream: one 8-bit raw sample in per transfer, one
// 24-bit RGB pixel out, sustained at one pixel per clock in both directions while the
// output side is ready. The pixel for raw sample k leaves with the transfer of sample
// k + width + 1, passing the line-store read, the queue and the output register after
// that transfer; after the frame's last sample send width + 1 flush items to drain it, and
// the last pixel carries frame_end. The rate is set by the single line-store RAM, read
// when a sample is taken and written back in the cycle after, and by the four-entry queue
// that lets the output side stall without stopping input until the queue fills. The line
// store is not cleared after reset and needs no clearing pass. Width and height writes
// restart the frame and are to be made only while the block is idle.
module bilinear_bayer_demosaic_core import bbd_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   bbd_req_if.sink               req_if,
   bbd_rsp_if.source             rsp_if,
   input  logic                  csr_we,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   q_status_type q_status;
   logic         q_push;
   entry_type    q_entry;
   logic         head_valid;
   entry_type    head_entry;
   logic         pop;

   bbd_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   bbd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .status     (q_status)
   );

   bbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );
endmodule
